// ===== rtl/core/mkse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkse_pkg
// Shared types, key codes and lookup functions for the keypad scan unit.
// ----------------------------------------------------------------------------
package mkse_pkg;

  localparam int unsigned ROW_COUNT = 4;

  localparam logic [3:0]  COLS_IDLE = 4'hF;
  localparam logic [30:0] NUM_MAX   = 31'h7FFF_FFFF;

  // ASCII key codes
  localparam logic [6:0] KEY_NONE = 7'h00;
  localparam logic [6:0] KEY_HASH = 7'h23;
  localparam logic [6:0] KEY_STAR = 7'h2A;
  localparam logic [6:0] KEY_0    = 7'h30;
  localparam logic [6:0] KEY_9    = 7'h39;
  localparam logic [6:0] KEY_A    = 7'h41;
  localparam logic [6:0] KEY_D    = 7'h44;

  // configuration register indexes
  localparam logic [1:0] CFG_SETTLE = 2'd0;
  localparam logic [1:0] CFG_GUARD  = 2'd1;
  localparam logic [1:0] CFG_MODE   = 2'd2;

  localparam logic [1:0] MODE_ANY     = 2'd0;
  localparam logic [1:0] MODE_LETTERS = 2'd1;

  // one scan-tick beat passed from front to back
  typedef struct packed {
    logic [3:0] row_drive;
    logic       report;     // scan completed with a key found
    logic [6:0] key;
  } mkse_evt_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] col;
  } mkse_col_t;

  function automatic logic [3:0] row_pattern(input logic [1:0] row);
    logic [3:0] p;
    unique case (row)
      2'd0:    p = 4'h7;
      2'd1:    p = 4'hB;
      2'd2:    p = 4'hD;
      default: p = 4'hE;
    endcase
    return p;
  endfunction

  function automatic mkse_col_t column_decode(input logic [3:0] cols);
    mkse_col_t r;
    r.hit = 1'b1;
    r.col = 2'd0;
    unique case (cols)
      4'h7:    r.col = 2'd0;
      4'hB:    r.col = 2'd1;
      4'hD:    r.col = 2'd2;
      4'hE:    r.col = 2'd3;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [6:0] k;
    unique case ({row, col})
      4'h0:    k = 7'h31; // 1
      4'h1:    k = 7'h32; // 2
      4'h2:    k = 7'h33; // 3
      4'h3:    k = 7'h41; // A
      4'h4:    k = 7'h34; // 4
      4'h5:    k = 7'h35; // 5
      4'h6:    k = 7'h36; // 6
      4'h7:    k = 7'h42; // B
      4'h8:    k = 7'h37; // 7
      4'h9:    k = 7'h38; // 8
      4'hA:    k = 7'h39; // 9
      4'hB:    k = 7'h43; // C
      4'hC:    k = KEY_STAR;
      4'hD:    k = KEY_0;
      4'hE:    k = KEY_HASH;
      default: k = KEY_D;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/matrix_keypad_scan_entry_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_keypad_scan_entry_unit
// 4x4 keypad scanner with key filter and decimal number entry.
// ----------------------------------------------------------------------------
// Each input beat is one scan tick carrying the sampled column lines; each
// tick yields exactly one result beat with the row pattern driven during that
// tick plus any key or number reported when a full scan ends. The unit takes
// one beat per cycle while in_stall is low; each beat's event is registered in
// the event queue, then taken through the report back into the output
// register. A two-entry queue decouples the two halves, so the input keeps
// flowing while a result waits on out_stall until the queue fills.
// Configuration writes (cfg_ready is always high) must be made while no
// beat is in flight: index 0 settle ticks, 1 guard ticks, 2 entry mode.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_entry_unit #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  wire         clk,
  input  wire         rst_n,
  // scan tick input
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [3:0]   in_column_lines,
  // result output
  output logic        out_valid,
  input  wire         out_stall,
  output logic [3:0]  out_row_drive,
  output logic        out_key_valid,
  output logic [6:0]  out_key_code,
  output logic        out_number_valid,
  output logic [30:0] out_number_value,
  // configuration writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [1:0]   cfg_index,
  input  wire [15:0]  cfg_data
);

  logic [15:0] settle_ticks_r;
  logic [15:0] guard_ticks_r;
  logic [1:0]  entry_mode_r;

  logic accept;
  logic q_full, q_avail, q_pop;
  mkse_pkg::mkse_evt_t front_evt, head_evt;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  // config registers; a write to an unused index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= 16'd5;
      guard_ticks_r  <= 16'd310;
      entry_mode_r   <= mkse_pkg::MODE_ANY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mkse_pkg::CFG_SETTLE: settle_ticks_r <= cfg_data;
        mkse_pkg::CFG_GUARD:  guard_ticks_r  <= cfg_data;
        mkse_pkg::CFG_MODE:   entry_mode_r   <= cfg_data[1:0];
        default:              ;
      endcase
    end
  end

  // scan front: row sequencing and key capture
  mkse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .column_lines (in_column_lines),
    .settle_ticks (settle_ticks_r),
    .evt          (front_evt)
  );

  mkse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_evt (front_evt),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head_evt (head_evt)
  );

  // report back: mode filter, guard window, number entry
  mkse_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .avail            (q_avail),
    .evt              (head_evt),
    .pop              (q_pop),
    .guard_ticks      (guard_ticks_r),
    .entry_mode       (entry_mode_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_drive    (out_row_drive),
    .out_key_valid    (out_key_valid),
    .out_key_code     (out_key_code),
    .out_number_valid (out_number_valid),
    .out_number_value (out_number_value)
  );

endmodule
`default_nettype wire

// ===== rtl/core/mkse_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkse_front
// Row scan sequencer: settle wait, column sampling, release wait, key capture.
// ----------------------------------------------------------------------------
module mkse_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  accept,
  input  wire [3:0]            column_lines,
  input  wire [15:0]           settle_ticks,
  output mkse_pkg::mkse_evt_t  evt
);

  logic [1:0]  row_r,    row_nxt;
  logic [15:0] settle_r, settle_nxt;
  logic        wait_r,   wait_nxt;
  logic        found_r,  found_nxt;
  logic [6:0]  key_r,    key_nxt;

  mkse_pkg::mkse_col_t dec;
  logic advance;

  always_comb begin
    dec        = mkse_pkg::column_decode(column_lines);
    row_nxt    = row_r;
    settle_nxt = settle_r;
    wait_nxt   = wait_r;
    found_nxt  = found_r;
    key_nxt    = key_r;
    advance    = 1'b0;

    evt.row_drive = mkse_pkg::row_pattern(row_r);
    evt.report    = 1'b0;
    evt.key       = key_r;

    if (wait_r) begin
      if (column_lines == mkse_pkg::COLS_IDLE) begin
        wait_nxt = 1'b0;
        advance  = 1'b1;
      end
    end else if (settle_r < settle_ticks) begin
      settle_nxt = settle_r + 16'd1;
    end else begin
      settle_nxt = '0;
      if (column_lines != mkse_pkg::COLS_IDLE) begin
        if (dec.hit) begin
          key_nxt   = mkse_pkg::key_lookup(row_r, dec.col);
          found_nxt = 1'b1;
        end
        wait_nxt = 1'b1;
      end else begin
        advance = 1'b1;
      end
    end

    // key capture and advance never coincide, so found_r is current here
    if (advance) begin
      if (row_r == 2'(mkse_pkg::ROW_COUNT - 1)) begin
        row_nxt    = '0;
        evt.report = found_r;
        found_nxt  = 1'b0;
      end else begin
        row_nxt = row_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      settle_r <= '0;
      wait_r   <= 1'b0;
      found_r  <= 1'b0;
      key_r    <= '0;
    end else if (accept) begin
      row_r    <= row_nxt;
      settle_r <= settle_nxt;
      wait_r   <= wait_nxt;
      found_r  <= found_nxt;
      key_r    <= key_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mkse_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkse_queue
// Two-entry event queue between scan front and report back.
// ----------------------------------------------------------------------------
module mkse_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  mkse_pkg::mkse_evt_t  push_evt,
  output logic                 full,
  input  wire                  pop,
  output logic                 avail,
  output mkse_pkg::mkse_evt_t  head_evt
);

  mkse_pkg::mkse_evt_t slot_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign avail    = (cnt_r != 2'd0);
  assign head_evt = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mkse_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkse_back
// Key filter, guard window and decimal entry; holds the result register.
// ----------------------------------------------------------------------------
module mkse_back #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  avail,
  input  mkse_pkg::mkse_evt_t  evt,
  output logic                 pop,
  input  wire [15:0]           guard_ticks,
  input  wire [1:0]            entry_mode,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [3:0]           out_row_drive,
  output logic                 out_key_valid,
  output logic [6:0]           out_key_code,
  output logic                 out_number_valid,
  output logic [30:0]          out_number_value
);

  logic [15:0] guard_r, guard_nxt;
  logic [30:0] acc_r,   acc_nxt;
  logic [3:0]  dc_r,    dc_nxt;
  logic        vld_r,   vld_nxt;

  logic [3:0]  row_nxt_o;
  logic        kv_nxt, nv_nxt;
  logic [6:0]  kc_nxt;
  logic [30:0] nval_nxt;

  logic [34:0] prod;
  logic [3:0]  digit;
  logic        is_digit;

  assign pop = avail && (!vld_r || !out_stall);

  always_comb begin
    digit    = 4'(evt.key - mkse_pkg::KEY_0);
    is_digit = (evt.key >= mkse_pkg::KEY_0) && (evt.key <= mkse_pkg::KEY_9);
    // acc * 10 + digit as shift-add; 35 bits hold the largest product
    prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {31'd0, digit};

    guard_nxt = (guard_r != 16'd0) ? guard_r - 16'd1 : guard_r;
    acc_nxt   = acc_r;
    dc_nxt    = dc_r;
    row_nxt_o = evt.row_drive;
    kv_nxt    = 1'b0;
    kc_nxt    = mkse_pkg::KEY_NONE;
    nv_nxt    = 1'b0;
    nval_nxt  = '0;

    if (evt.report) begin
      if (entry_mode[1]) begin
        if (guard_r == 16'd0) begin
          kv_nxt    = 1'b1;
          kc_nxt    = evt.key;
          guard_nxt = guard_ticks;
          if (is_digit) begin
            acc_nxt = (prod > {4'b0000, mkse_pkg::NUM_MAX}) ? mkse_pkg::NUM_MAX : prod[30:0];
            dc_nxt  = dc_r + 4'd1;
          end
          if (evt.key == mkse_pkg::KEY_HASH || dc_nxt >= 4'(MAX_DIGITS)) begin
            nv_nxt   = 1'b1;
            nval_nxt = acc_nxt;
            acc_nxt  = '0;
            dc_nxt   = '0;
          end
        end
      end else if (entry_mode == mkse_pkg::MODE_LETTERS) begin
        if (evt.key >= mkse_pkg::KEY_A && evt.key <= mkse_pkg::KEY_D) begin
          kv_nxt = 1'b1;
          kc_nxt = evt.key;
        end
      end else begin
        kv_nxt = 1'b1;
        kc_nxt = evt.key;
      end
    end

    vld_nxt = pop ? 1'b1 : (vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_r <= '0;
      acc_r   <= '0;
      dc_r    <= '0;
      vld_r   <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (pop) begin
        guard_r <= guard_nxt;
        acc_r   <= acc_nxt;
        dc_r    <= dc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_row_drive    <= row_nxt_o;
      out_key_valid    <= kv_nxt;
      out_key_code     <= kc_nxt;
      out_number_valid <= nv_nxt;
      out_number_value <= nval_nxt;
    end
  end

  assign out_valid = vld_r;

endmodule
`default_nettype wire

// ===== rtl/core/mkse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mkse_checker
// Port-level checks on the keypad scan unit result channel.
// ----------------------------------------------------------------------------
module mkse_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [3:0]  out_row_drive,
  input wire        out_key_valid,
  input wire [6:0]  out_key_code,
  input wire        out_number_valid,
  input wire [30:0] out_number_value
);

  // a number is only reported together with the key that completed it
  a_num_with_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_number_valid |-> out_key_valid)
    else $error("number beat without key");

  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_key_valid |-> out_key_code == 7'h00 && !out_number_valid)
    else $error("key code set without key_valid");

  a_row_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(~out_row_drive))
    else $error("row drive not one row low");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_drive) &&
      $stable(out_key_code) && $stable(out_number_value))
    else $error("stalled result changed");

endmodule

bind matrix_keypad_scan_entry_unit mkse_checker u_mkse_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_row_drive    (out_row_drive),
  .out_key_valid    (out_key_valid),
  .out_key_code     (out_key_code),
  .out_number_valid (out_number_valid),
  .out_number_value (out_number_value)
);
`default_nettype wire

// ===== bench/matrix_keypad_scan_entry_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scan_entry_unit_tb
// Self-checking bench for the keypad scan unit. A virtual 4x4 keypad answers
// the row the unit drives, so presses land where a real key matrix would put
// them; a scoreboard tracks the scan state and checks every result beat.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_entry_unit_tb;

  localparam int MAX_DIGITS = 10;

  // entry modes beyond the two named in the package; bit 1 selects entry
  localparam logic [1:0] MODE_ENTRY     = 2'd2;
  localparam logic [1:0] MODE_ENTRY_ALT = 2'd3;

  // key legend, row-major, first character in the top byte
  localparam logic [127:0] KEY_CHARS = "123A456B789C*0#D";
  // keypad position of each digit, digit d in bits [4d +: 4]
  localparam logic [39:0]  DIGIT_POS = {4'd10, 4'd9, 4'd8, 4'd6, 4'd5,
                                        4'd4, 4'd2, 4'd1, 4'd0, 4'd13};
  localparam int           POS_HASH  = 14;

  localparam logic [15:0] REG_MAX     = 16'hFFFF;
  localparam int          TOTAL_TICKS = 950;   // directed plus random ticks
  localparam int          CALM_TICKS  = 875;   // no idling past this point

  typedef struct packed {
    logic [3:0]  row_drive;
    logic        key_valid;
    logic [6:0]  key_code;
    logic        number_valid;
    logic [30:0] number_value;
  } scan_report_t;

  // --------------------------------------------------------------------------
  // Scan state tracker: mirrors the unit tick by tick and queues the report
  // each accepted tick must produce.
  // --------------------------------------------------------------------------
  class keypad_scoreboard;
    logic [15:0]  settle_ticks;
    logic [15:0]  guard_ticks;
    logic [1:0]   entry_mode;
    logic [1:0]   row_index;
    logic [15:0]  settle_count;
    logic [15:0]  guard_count;
    bit           awaiting_release;
    bit           found_flag;
    logic [6:0]   found_key;
    logic [30:0]  accumulator;
    logic [3:0]   digit_count;
    int           scans_done;
    int           errors;
    scan_report_t expected_reports[$];

    function new();
      settle_ticks     = 16'd5;
      guard_ticks      = 16'd310;
      entry_mode       = mkse_pkg::MODE_ANY;
      row_index        = '0;
      settle_count     = '0;
      guard_count      = '0;
      awaiting_release = 1'b0;
      found_flag       = 1'b0;
      found_key        = mkse_pkg::KEY_NONE;
      accumulator      = '0;
      digit_count      = '0;
      scans_done       = 0;
      errors           = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        mkse_pkg::CFG_SETTLE: settle_ticks = data;
        mkse_pkg::CFG_GUARD:  guard_ticks  = data;
        mkse_pkg::CFG_MODE:   entry_mode   = data[1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic [3:0] cols);
      scan_report_t rep;
      logic [1:0]   row;
      logic [1:0]   col;
      logic [6:0]   k;
      logic [63:0]  wide;
      bit           advance;
      bit           blocked;
      bit           hit;
      rep     = '0;
      row     = row_index;
      advance = 1'b0;
      blocked = guard_count != 0;
      hit     = 1'b1;
      col     = 2'd0;
      rep.row_drive = ~(4'b1000 >> row);
      if (blocked) guard_count = guard_count - 16'd1;
      case (cols)
        4'h7:    col = 2'd0;
        4'hB:    col = 2'd1;
        4'hD:    col = 2'd2;
        4'hE:    col = 2'd3;
        default: hit = 1'b0;
      endcase
      if (awaiting_release) begin
        if (cols == mkse_pkg::COLS_IDLE) begin
          awaiting_release = 1'b0;
          advance          = 1'b1;
        end
      end else if (settle_count < settle_ticks) begin
        settle_count = settle_count + 16'd1;
      end else begin
        settle_count = '0;
        if (cols != mkse_pkg::COLS_IDLE) begin
          if (hit) begin
            found_key  = 7'(KEY_CHARS[127 - 8 * (4 * row + col) -: 8]);
            found_flag = 1'b1;
          end
          awaiting_release = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      if (advance) begin
        if (row == 2'd3) begin
          row_index  = '0;
          scans_done++;
          if (found_flag) begin
            k = found_key;
            if (entry_mode[1]) begin
              if (!blocked) begin
                rep.key_valid = 1'b1;
                rep.key_code  = k;
                guard_count   = guard_ticks;
                if (k >= mkse_pkg::KEY_0 && k <= mkse_pkg::KEY_9) begin
                  wide = {33'd0, accumulator} * 64'd10 + {57'd0, k - mkse_pkg::KEY_0};
                  accumulator = (wide > {33'd0, mkse_pkg::NUM_MAX}) ?
                                mkse_pkg::NUM_MAX : wide[30:0];
                  digit_count = digit_count + 4'd1;
                end
                if (k == mkse_pkg::KEY_HASH || digit_count >= MAX_DIGITS) begin
                  rep.number_valid = 1'b1;
                  rep.number_value = accumulator;
                  accumulator      = '0;
                  digit_count      = '0;
                end
              end
            end else if (entry_mode == mkse_pkg::MODE_LETTERS) begin
              if (k >= mkse_pkg::KEY_A && k <= mkse_pkg::KEY_D) begin
                rep.key_valid = 1'b1;
                rep.key_code  = k;
              end
            end else begin
              rep.key_valid = 1'b1;
              rep.key_code  = k;
            end
          end
          found_flag = 1'b0;
        end else begin
          row_index = row + 2'd1;
        end
      end
      expected_reports.push_back(rep);
    endfunction

    function void check_report(scan_report_t got);
      scan_report_t want;
      if (expected_reports.size() == 0) begin
        $error("result beat with no report pending: %0h", got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.row_drive !== want.row_drive) begin
        $error("row_drive: expected %0h, got %0h", want.row_drive, got.row_drive);
        errors++;
      end
      if (got.key_valid !== want.key_valid) begin
        $error("key_valid: expected %0h, got %0h", want.key_valid, got.key_valid);
        errors++;
      end
      if (got.key_code !== want.key_code) begin
        $error("key_code: expected %0h, got %0h", want.key_code, got.key_code);
        errors++;
      end
      if (got.number_valid !== want.number_valid) begin
        $error("number_valid: expected %0h, got %0h", want.number_valid, got.number_valid);
        errors++;
      end
      if (got.number_value !== want.number_value) begin
        $error("number_value: expected %0d, got %0d", want.number_value, got.number_value);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_column_lines;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_row_drive;
  logic        out_key_valid;
  logic [6:0]  out_key_code;
  logic        out_number_valid;
  logic [30:0] out_number_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  keypad_scoreboard sb = new();

  int tick_count;
  bit idle_on;      // random gaps and stalls allowed right now
  bit phase_idle;   // this phase idles at all

  matrix_keypad_scan_entry_unit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_column_lines  (in_column_lines),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_drive    (out_row_drive),
    .out_key_valid    (out_key_valid),
    .out_key_code     (out_key_code),
    .out_number_valid (out_number_valid),
    .out_number_value (out_number_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: every beat taken off the output is checked against the
  // oldest pending report. Values are read in the active region of the edge,
  // so they are the ones that held before it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_report({out_row_drive, out_key_valid, out_key_code,
                       out_number_valid, out_number_value});
  end

  // Receiver back-pressure: random stall bursts while idling is on.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // Column levels a real matrix shows: a held key pulls its column low only
  // while its own row is the one driven.
  function automatic logic [3:0] keypad_columns(logic [15:0] held, logic [1:0] row);
    logic [3:0] cols;
    cols = mkse_pkg::COLS_IDLE;
    for (int c = 0; c < 4; c++)
      if (held[4 * row + c]) cols[3 - c] = 1'b0;
    return cols;
  endfunction

  // One scan tick beat; may open with an input gap.
  task automatic send_tick(input logic [3:0] cols);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_column_lines <= cols;
    do @(posedge clk); while (in_stall);
    sb.note_tick(cols);
    tick_count++;
  endtask

  // Fixed tick sequence, first nibble first.
  task automatic play_ticks(input logic [31:0] seq, input int n);
    for (int i = 0; i < n; i++) send_tick(seq[31 - 4 * i -: 4]);
  endtask

  task automatic keypad_tick(input logic [15:0] held);
    send_tick(keypad_columns(held, sb.row_index));
  endtask

  // Hold keys until the scan catches one, linger a little, let go, and
  // usually ride out the rest of the scan so the key gets reported.
  task automatic tap_keys(input logic [15:0] held);
    int n;
    int scan0;
    int span;
    span = 4 * (int'(sb.settle_ticks) + 1) + 8;
    n = 0;
    while (!sb.awaiting_release && n < span) begin
      keypad_tick(held);
      n++;
    end
    repeat ($urandom_range(0, 3)) keypad_tick(held);
    keypad_tick('0);
    if ($urandom_range(0, 3) != 0) begin
      scan0 = sb.scans_done;
      n = 0;
      while (sb.scans_done == scan0 && n < span) begin
        keypad_tick('0);
        n++;
      end
    end
  endtask

  // Key position; entry modes lean on digits and '#', with extra nines to
  // push the value into saturation.
  function automatic int pick_key(bit numeric);
    if (numeric) begin
      if ($urandom_range(0, 7) == 0) return POS_HASH;
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 3) == 0) return int'(DIGIT_POS[4 * 9 +: 4]);
        return int'(DIGIT_POS[4 * $urandom_range(0, 9) +: 4]);
      end
    end
    return $urandom_range(0, 15);
  endfunction

  task automatic cfg_beat(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic write_settings(input logic [15:0] settle, input logic [15:0] guard,
                                input logic [15:0] mode_word);
    cfg_beat(mkse_pkg::CFG_SETTLE, settle);
    cfg_beat(mkse_pkg::CFG_GUARD, guard);
    cfg_beat(mkse_pkg::CFG_MODE, mode_word);
    cfg_valid <= 1'b0;
  endtask

  // Every tick yields a report, so an empty queue means nothing in flight.
  task automatic wait_idle();
    while (sb.expected_reports.size() != 0) @(posedge clk);
  endtask

  // A stretch of keypad activity: mostly clean taps, some chords, some line
  // noise and quiet ticks; only line noise when noise_only is set.
  task automatic run_phase(input int ticks_wanted, input bit noise_only);
    int start;
    int r;
    start = tick_count;
    while (tick_count - start < ticks_wanted) begin
      idle_on = phase_idle && tick_count < CALM_TICKS;
      r = $urandom_range(0, 99);
      if (noise_only || (r >= 80 && r < 92))
        repeat ($urandom_range(1, 6)) send_tick(4'($urandom_range(0, 15)));
      else if (r < 70)
        tap_keys(16'd1 << pick_key(sb.entry_mode[1]));
      else if (r < 80)
        tap_keys((16'd1 << pick_key(1'b0)) | (16'd1 << pick_key(1'b0)));
      else
        repeat ($urandom_range(1, 8)) send_tick(mkse_pkg::COLS_IDLE);
    end
    in_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int          phase;
    logic [15:0] settle;
    logic [15:0] guard;
    logic [1:0]  mode;

    in_valid        = 1'b0;
    in_column_lines = mkse_pkg::COLS_IDLE;
    cfg_valid       = 1'b0;
    cfg_index       = mkse_pkg::CFG_SETTLE;
    cfg_data        = '0;
    rst_n           = 1'b0;
    idle_on         = 1'b0;
    phase_idle      = 1'b0;
    tick_count      = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, zero settle so every tick samples its row.
    // Any-key mode: '1' in row 0, all columns low in row 1 (no key but a
    // release wait), 'D' in row 3; the last key of the scan wins.
    write_settings(16'd0, 16'd0, {14'd0, mkse_pkg::MODE_ANY});
    play_ticks(32'h7F0FFEF0, 7);
    in_valid <= 1'b0;
    wait_idle();

    // Entry mode: '#' with no digits gives a zero number.
    write_settings(16'd0, 16'd0, {14'd0, MODE_ENTRY});
    play_ticks(32'hFFFDF000, 5);
    in_valid <= 1'b0;
    wait_idle();

    // Letters mode: 'A' is reported, '1' is dropped.
    write_settings(16'd0, 16'd0, {14'd0, mkse_pkg::MODE_LETTERS});
    play_ticks(32'hEFFFF000, 5);
    play_ticks(32'h7FFFF000, 5);
    in_valid <= 1'b0;

    // Random phases, settings picked fresh each time while the unit is idle.
    phase = 0;
    while (tick_count < TOTAL_TICKS) begin
      wait_idle();
      phase_idle = $urandom_range(0, 4) != 0;
      if (phase == 3) begin
        // longest settle: the scan never gets to sample here
        write_settings(REG_MAX, 16'($urandom_range(0, 40)), {14'd0, mkse_pkg::MODE_ANY});
        run_phase(24, 1'b1);
      end else begin
        case ($urandom_range(0, 9))
          4, 5, 6, 7: settle = 16'($urandom_range(1, 3));
          8:          settle = 16'($urandom_range(4, 8));
          default:    settle = 16'd0;
        endcase
        case ($urandom_range(0, 9))
          4, 5, 6, 7: guard = 16'($urandom_range(1, 40));
          8:          guard = 16'd310;
          9:          guard = 16'($urandom_range(41, 200));
          default:    guard = 16'd0;
        endcase
        case ($urandom_range(0, 9))
          0, 1:    mode = mkse_pkg::MODE_ANY;
          2, 3:    mode = mkse_pkg::MODE_LETTERS;
          9:       mode = MODE_ENTRY_ALT;
          default: mode = MODE_ENTRY;
        endcase
        // upper bits of the mode word are don't-care
        write_settings(settle, guard, {14'($urandom), mode});
        run_phase($urandom_range(60, 200), 1'b0);
      end
      phase++;
    end

    // Closing phase: longest guard, so only the first entry key gets through.
    wait_idle();
    write_settings(16'd0, REG_MAX, {14'($urandom), MODE_ENTRY});
    run_phase(40, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mkse_pkg.sv
rtl/core/mkse_front.sv
rtl/core/mkse_queue.sv
rtl/core/mkse_back.sv
rtl/core/matrix_keypad_scan_entry_unit.sv
rtl/core/mkse_checker.sv
bench/matrix_keypad_scan_entry_unit_tb.sv
